[src/nucm_pkg.sv]
`default_nettype none

package nucm_pkg;

  // pixel layout: red in 23..16, green in 15..8, blue in 7..0
  localparam int unsigned ColorW = 24;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned DistW  = 18;
  localparam int unsigned IndexW = 12;

  typedef logic [ColorW-1:0] color_t;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_MATCH = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_LOADED  = 3'd0,
    STAT_DROPPED = 3'd1,
    STAT_MATCH   = 3'd2,
    STAT_NONE    = 3'd3,
    STAT_CLEARED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // control carried alongside each store entry through the scan pipeline
  typedef struct packed {
    logic valid;
    logic last;
    logic used;
  } scan_tag_t;

endpackage

`default_nettype wire

[src/nucm_dist.sv]
`default_nettype none

module nucm_dist
  import nucm_pkg::*;
#(
  parameter int unsigned ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire color_t            target,
  input  wire scan_tag_t         in_tag,
  input  wire logic [ADDR_W-1:0] in_idx,
  input  wire color_t            in_color,
  output scan_tag_t              out_tag,
  output logic      [ADDR_W-1:0] out_idx,
  output color_t                 out_color,
  output logic      [DistW-1:0]  out_dist
);

  logic signed [ChanW:0]     dr, dg, db;
  logic        [2*ChanW-1:0] pr, pg, pb;
  logic        [2*ChanW-1:0] sq_r, sq_g, sq_b;

  // channel differences and their squares, a square fits in 16 bits
  always_comb begin
    dr = $signed({1'b0, target[23:16]}) - $signed({1'b0, in_color[23:16]});
    dg = $signed({1'b0, target[15:8]})  - $signed({1'b0, in_color[15:8]});
    db = $signed({1'b0, target[7:0]})   - $signed({1'b0, in_color[7:0]});
    pr = (2*ChanW)'(dr) * (2*ChanW)'(dr);
    pg = (2*ChanW)'(dg) * (2*ChanW)'(dg);
    pb = (2*ChanW)'(db) * (2*ChanW)'(db);
  end

  // square stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag <= '0;
    end else begin
      out_tag <= in_tag;
    end
    out_idx   <= in_idx;
    out_color <= in_color;
    sq_r      <= pr;
    sq_g      <= pg;
    sq_b      <= pb;
  end

  // sum of squares, at most 195075
  assign out_dist = DistW'(sq_r) + DistW'(sq_g) + DistW'(sq_b);

endmodule

`default_nettype wire

[src/nearest_unused_color_match.sv]
// load and clear: result valid in the cycle after the input beat is accepted
// match: one store entry read per cycle
//   through one shared distance unit; an empty store answers in the next cycle
// one command in flight at a time; ready again once the result beat can leave
// reset clears the load count and the sequencer; store contents are not cleared,
//   as only entries loaded since the last clear are ever scanned
`default_nettype none

module nearest_unused_color_match
  import nucm_pkg::*;
#(
  parameter int unsigned SOURCE_DEPTH = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         cmd,
  input  wire logic [ChanW-1:0]   red,
  input  wire logic [ChanW-1:0]   green,
  input  wire logic [ChanW-1:0]   blue,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              status,
  output logic [ChanW-1:0]        out_red,
  output logic [ChanW-1:0]        out_green,
  output logic [ChanW-1:0]        out_blue,
  output logic [IndexW-1:0]       match_index,
  output logic [DistW-1:0]        distance_sq
);

  localparam int unsigned ADDR_W  = (SOURCE_DEPTH > 1) ? $clog2(SOURCE_DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(SOURCE_DEPTH + 1);

  state_t state, state_next;

  // store entry: used mark in bit 24, color below
  logic [ColorW:0]      mem [SOURCE_DEPTH];
  logic [ColorW:0]      rd_data;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [ColorW:0]      mem_wdata;

  logic [COUNT_W-1:0]   loaded_count;
  logic [ADDR_W-1:0]    addr;
  color_t               tgt;
  logic                 accept;
  logic                 issue_last;
  logic                 full;

  logic                 p1_valid;
  logic                 p1_last;
  logic [ADDR_W-1:0]    p1_idx;

  scan_tag_t            d_tag;
  logic [ADDR_W-1:0]    d_idx;
  color_t               d_color;
  logic [DistW-1:0]     d_dist;
  logic                 better;

  logic                 found;
  logic [ADDR_W-1:0]    best_idx;
  color_t               best_color;
  logic [DistW-1:0]     best_dist;

  assign accept     = in_valid && in_ready;
  assign full       = (loaded_count == COUNT_W'(SOURCE_DEPTH));
  assign issue_last = (COUNT_W'(addr) + COUNT_W'(1)) == loaded_count;
  assign better     = d_tag.valid && !d_tag.used && (!found || (d_dist < best_dist));

  // sequencer next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !out_valid || out_ready;
        if (in_valid && in_ready && (cmd_t'(cmd) == CMD_MATCH) && (loaded_count != '0)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (d_tag.valid && d_tag.last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // store write port: loads and used marks
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = best_idx;
    mem_wdata = {1'b1, best_color};
    if (state == ST_FINISH) begin
      mem_we = found;
    end else if (accept && (cmd_t'(cmd) == CMD_LOAD) && !full) begin
      mem_we    = 1'b1;
      mem_waddr = loaded_count[ADDR_W-1:0];
      mem_wdata = {1'b0, red, green, blue};
    end
  end

  // store with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[addr];
  end

  // scan address and read-stage tags
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= (state == ST_SCAN);
    end
    p1_last <= issue_last;
    p1_idx  <= addr;
    if (state == ST_SCAN) begin
      addr <= addr + ADDR_W'(1);
    end else begin
      addr <= '0;
    end
  end

  nucm_dist #(
    .ADDR_W (ADDR_W)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .target    (tgt),
    .in_tag    ('{valid: p1_valid, last: p1_last, used: rd_data[ColorW]}),
    .in_idx    (p1_idx),
    .in_color  (rd_data[ColorW-1:0]),
    .out_tag   (d_tag),
    .out_idx   (d_idx),
    .out_color (d_color),
    .out_dist  (d_dist)
  );

  // running best candidate, strict compare keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (accept) begin
      found <= 1'b0;
    end else if (better) begin
      found <= 1'b1;
    end
    if (better) begin
      best_idx   <= d_idx;
      best_color <= d_color;
      best_dist  <= d_dist;
    end
  end

  // load count and target
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
    end else if (accept) begin
      case (cmd_t'(cmd))
        CMD_LOAD:  if (!full) loaded_count <= loaded_count + COUNT_W'(1);
        CMD_CLEAR: loaded_count <= '0;
        default:   ;
      endcase
    end
    if (accept) begin
      tgt <= {red, green, blue};
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH) begin
      out_valid <= 1'b1;
    end else if (accept) begin
      out_valid <= !((cmd_t'(cmd) == CMD_NOP) ||
                     ((cmd_t'(cmd) == CMD_MATCH) && (loaded_count != '0)));
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (state == ST_FINISH) begin
      status      <= found ? STAT_MATCH : STAT_NONE;
      out_red     <= found ? best_color[23:16] : '0;
      out_green   <= found ? best_color[15:8]  : '0;
      out_blue    <= found ? best_color[7:0]   : '0;
      match_index <= found ? IndexW'(best_idx) : '0;
      distance_sq <= found ? best_dist : '0;
    end else if (accept) begin
      out_red     <= '0;
      out_green   <= '0;
      out_blue    <= '0;
      match_index <= '0;
      distance_sq <= '0;
      case (cmd_t'(cmd))
        CMD_LOAD:  status <= full ? STAT_DROPPED : STAT_LOADED;
        CMD_CLEAR: status <= STAT_CLEARED;
        default:   status <= STAT_NONE;
      endcase
    end
  end

  // output register stays empty while a scan runs
  a_scan_out_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_DRAIN) |-> !out_valid)
    else $error("result beat pending during scan");

  // load count never exceeds the store depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= COUNT_W'(SOURCE_DEPTH))
    else $error("load count beyond store depth");

  // pipeline carries entries only while a match is in progress
  a_pipe_idle: assert property (@(posedge clk) disable iff (rst)
    (p1_valid || d_tag.valid) |-> (state != ST_IDLE))
    else $error("scan pipeline active while idle");

  // finishing a scan always presents a result next cycle
  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |=> (out_valid && (state == ST_IDLE)))
    else $error("scan finished without result beat");

  // chosen distance stays within the rgb range
  a_best_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && found) |-> (best_dist <= DistW'(195075)))
    else $error("best distance out of range");

endmodule

`default_nettype wire
